@@ rtl/core/green_lagrange_strain_2d_defines.svh @@
// assertion macros for the green-lagrange strain block
`ifndef GREEN_LAGRANGE_STRAIN_2D_DEFINES_SVH
`define GREEN_LAGRANGE_STRAIN_2D_DEFINES_SVH
`ifndef ASSERT_OFF
// implication checked every cycle outside reset
`define GLS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// next-cycle implication, also checked while reset is held
`define GLS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) ante |=> cons) else $error(msg);
`else
`define GLS_ASSERT(lbl, clk, rstn, prop, msg)
`define GLS_ASSERT_NEXT(lbl, clk, ante, cons, msg)
`endif
`endif

@@ rtl/core/gls_pkg.sv @@
// shared constants and request/result types for the green-lagrange strain block
package gls_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIELD_W        = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] disp_n0_x;
        logic signed [FIELD_W-1:0] disp_n0_y;
        logic signed [FIELD_W-1:0] disp_n1_x;
        logic signed [FIELD_W-1:0] disp_n1_y;
        logic signed [FIELD_W-1:0] disp_n2_x;
        logic signed [FIELD_W-1:0] disp_n2_y;
        logic signed [FIELD_W-1:0] grad_n0_x;
        logic signed [FIELD_W-1:0] grad_n0_y;
        logic signed [FIELD_W-1:0] grad_n1_x;
        logic signed [FIELD_W-1:0] grad_n1_y;
        logic signed [FIELD_W-1:0] grad_n2_x;
        logic signed [FIELD_W-1:0] grad_n2_y;
    } t_gls_req;

    typedef struct packed {
        logic signed [FIELD_W-1:0] def_grad_xx;
        logic signed [FIELD_W-1:0] def_grad_xy;
        logic signed [FIELD_W-1:0] def_grad_yx;
        logic signed [FIELD_W-1:0] def_grad_yy;
        logic signed [FIELD_W-1:0] strain_xx;
        logic signed [FIELD_W-1:0] strain_xy;
        logic signed [FIELD_W-1:0] strain_yx;
        logic signed [FIELD_W-1:0] strain_yy;
        logic                      saturated;
    } t_gls_res;

endpackage

@@ rtl/core/gls_prod.sv @@
// registered fixed point product with floor shift and saturation
module gls_prod #(
    parameter int DW = gls_pkg::DATA_WIDTH_DEF,
    parameter int FB = gls_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [DW-1:0] o_q,
    output logic                 o_sat
);

    localparam logic signed [2*DW-1:0] L_MAX = {{(DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [2*DW-1:0] L_MIN = {{(DW+1){1'b1}}, {(DW-1){1'b0}}};

    logic signed [2*DW-1:0] r_prod;
    logic signed [2*DW-1:0] w_sh;

    always_ff @(posedge i_clk) begin
        r_prod <= (2*DW)'(i_a) * (2*DW)'(i_b);
    end

    // arithmetic shift gives floor toward minus infinity
    assign w_sh = r_prod >>> FB;

    always_comb begin
        if (w_sh > L_MAX) begin
            o_q   = L_MAX[DW-1:0];
            o_sat = 1'b1;
        end else if (w_sh < L_MIN) begin
            o_q   = L_MIN[DW-1:0];
            o_sat = 1'b1;
        end else begin
            o_q   = w_sh[DW-1:0];
            o_sat = 1'b0;
        end
    end

endmodule

@@ rtl/core/green_lagrange_strain_2d.sv @@
// green-lagrange strain of a 2d three-node triangle: F = I + H, E = 0.5*(F^T F - I)
// o_strobe is the last valid bit, which follows a taken request through every stage
// throughput: one request every cycle once busy is low, results leave in request order
// busy is high only from reset until the first clock after reset is released
// the receiver cannot stall; results are shown for one cycle with o_strobe
`include "green_lagrange_strain_2d_defines.svh"
module green_lagrange_strain_2d #(
    parameter int DATA_WIDTH = gls_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = gls_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  gls_pkg::t_gls_req i_req,
    output logic              o_strobe,
    output gls_pkg::t_gls_res o_res
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int FW = gls_pkg::FIELD_W;
    // wide enough for a three-term sum and for the unit constant
    localparam int LW = ((DW > FB) ? DW : FB) + 2;

    localparam logic signed [DW-1:0] L_MAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] L_MIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [LW-1:0] L_ONE  = {{(LW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
    localparam logic signed [LW-1:0] L_HALF = {{(LW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    // request handshake; busy only covers reset
    logic r_busy;
    logic w_accept;

    assign busy     = r_busy;
    assign w_accept = start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // valid bits, one per stage
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // unpack nodal vectors: index 2*node + axis
    logic signed [DW-1:0] w_u [6];
    logic signed [DW-1:0] w_g [6];

    always_comb begin
        w_u[0] = DW'(i_req.disp_n0_x);
        w_u[1] = DW'(i_req.disp_n0_y);
        w_u[2] = DW'(i_req.disp_n1_x);
        w_u[3] = DW'(i_req.disp_n1_y);
        w_u[4] = DW'(i_req.disp_n2_x);
        w_u[5] = DW'(i_req.disp_n2_y);
        w_g[0] = DW'(i_req.grad_n0_x);
        w_g[1] = DW'(i_req.grad_n0_y);
        w_g[2] = DW'(i_req.grad_n1_x);
        w_g[3] = DW'(i_req.grad_n1_y);
        w_g[4] = DW'(i_req.grad_n2_x);
        w_g[5] = DW'(i_req.grad_n2_y);
    end

    // stage 1: twelve products u(n,i)*g(n,j), product k = (2*i+j)*3 + n
    logic signed [DW-1:0] w_hq   [12];
    logic        [11:0]   w_hsat;

    for (genvar i = 0; i < 2; i++) begin : g_hrow
        for (genvar j = 0; j < 2; j++) begin : g_hcol
            for (genvar n = 0; n < 3; n++) begin : g_node
                gls_prod #(
                    .DW (DW),
                    .FB (FB)
                ) u_hprod (
                    .i_clk (i_clk),
                    .i_a   (w_u[2*n+i]),
                    .i_b   (w_g[2*n+j]),
                    .o_q   (w_hq[(2*i+j)*3+n]),
                    .o_sat (w_hsat[(2*i+j)*3+n])
                );
            end
        end
    end

    // stage 2: exact sum of the three clipped products per entry of H
    logic signed [LW-1:0] r_hsum [4];
    logic                 r_sat2;

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r_hsum[e] <= LW'(w_hq[e*3]) + LW'(w_hq[e*3+1]) + LW'(w_hq[e*3+2]);
        end
        r_sat2 <= |w_hsat;
    end

    // stage 3: clip H, add identity on the diagonal, clip again to F
    logic signed [DW-1:0] n_f  [4];
    logic        [3:0]    n_fsat;
    logic signed [DW-1:0] r_f3 [4];
    logic                 r_sat3;

    always_comb begin
        logic signed [DW-1:0] hc;
        logic signed [LW-1:0] fd;
        logic                 s;
        for (int e = 0; e < 4; e++) begin
            s = 1'b0;
            if (r_hsum[e] > LW'(L_MAX)) begin
                hc = L_MAX;
                s  = 1'b1;
            end else if (r_hsum[e] < LW'(L_MIN)) begin
                hc = L_MIN;
                s  = 1'b1;
            end else begin
                hc = r_hsum[e][DW-1:0];
            end
            // diagonal entries xx and yy
            if (e == 0 || e == 3) begin
                fd = LW'(hc) + L_ONE;
                if (fd > LW'(L_MAX)) begin
                    hc = L_MAX;
                    s  = 1'b1;
                end else if (fd < LW'(L_MIN)) begin
                    hc = L_MIN;
                    s  = 1'b1;
                end else begin
                    hc = fd[DW-1:0];
                end
            end
            n_f[e]    = hc;
            n_fsat[e] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r_f3[e] <= n_f[e];
        end
        r_sat3 <= r_sat2 | (|n_fsat);
    end

    // stage 4: products for C = F^T F; pairs for xx, xy and yy
    // C(i,j) = F(0,i)*F(0,j) + F(1,i)*F(1,j), F(r,c) held at index 2*r+c
    logic signed [DW-1:0] w_ca [6];
    logic signed [DW-1:0] w_cb [6];
    logic signed [DW-1:0] w_cq [6];
    logic        [5:0]    w_csat;
    logic signed [DW-1:0] r_f4 [4];
    logic                 r_sat4;

    always_comb begin
        w_ca[0] = r_f3[0]; w_cb[0] = r_f3[0];
        w_ca[1] = r_f3[2]; w_cb[1] = r_f3[2];
        w_ca[2] = r_f3[0]; w_cb[2] = r_f3[1];
        w_ca[3] = r_f3[2]; w_cb[3] = r_f3[3];
        w_ca[4] = r_f3[1]; w_cb[4] = r_f3[1];
        w_ca[5] = r_f3[3]; w_cb[5] = r_f3[3];
    end

    for (genvar p = 0; p < 6; p++) begin : g_cprod
        gls_prod #(
            .DW (DW),
            .FB (FB)
        ) u_cprod (
            .i_clk (i_clk),
            .i_a   (w_ca[p]),
            .i_b   (w_cb[p]),
            .o_q   (w_cq[p]),
            .o_sat (w_csat[p])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r_f4[e] <= r_f3[e];
        end
        r_sat4 <= r_sat3;
    end

    // stage 5: C kept exact, floor halve, take off one half on the diagonal, clip
    logic signed [DW-1:0] n_e    [3];
    logic        [2:0]    n_esat;
    logic signed [DW-1:0] r_fo   [4];
    logic signed [DW-1:0] r_e    [3];
    logic                 r_sato;

    always_comb begin
        logic signed [DW:0]   c;
        logic signed [LW-1:0] v;
        for (int k = 0; k < 3; k++) begin
            c = (DW+1)'(w_cq[2*k]) + (DW+1)'(w_cq[2*k+1]);
            v = LW'(c >>> 1);
            // k = 0 is xx, k = 2 is yy
            if (k != 1) begin
                v = v - L_HALF;
            end
            n_esat[k] = 1'b0;
            if (v > LW'(L_MAX)) begin
                n_e[k]    = L_MAX;
                n_esat[k] = 1'b1;
            end else if (v < LW'(L_MIN)) begin
                n_e[k]    = L_MIN;
                n_esat[k] = 1'b1;
            end else begin
                n_e[k] = v[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < 4; e++) begin
            r_fo[e] <= r_f4[e];
        end
        for (int k = 0; k < 3; k++) begin
            r_e[k] <= n_e[k];
        end
        r_sato <= r_sat4 | (|w_csat) | (|n_esat);
    end

    // result port, zero above DATA_WIDTH
    assign o_strobe          = r_v5;
    assign o_res.def_grad_xx = FW'($unsigned(r_fo[0]));
    assign o_res.def_grad_xy = FW'($unsigned(r_fo[1]));
    assign o_res.def_grad_yx = FW'($unsigned(r_fo[2]));
    assign o_res.def_grad_yy = FW'($unsigned(r_fo[3]));
    assign o_res.strain_xx   = FW'($unsigned(r_e[0]));
    assign o_res.strain_xy   = FW'($unsigned(r_e[1]));
    assign o_res.strain_yx   = FW'($unsigned(r_e[1]));
    assign o_res.strain_yy   = FW'($unsigned(r_e[2]));
    assign o_res.saturated   = r_sato;

    // strain is symmetric by construction
    `GLS_ASSERT(a_strain_sym, i_clk, i_rst_n, o_strobe |-> (o_res.strain_xy == o_res.strain_yx), "strain not symmetric")
    // diagonal strain comes from a sum of squares, never below minus one half
    `GLS_ASSERT(a_exx_floor, i_clk, i_rst_n, o_strobe |-> (LW'(r_e[0]) >= -L_HALF && LW'(r_e[2]) >= -L_HALF), "diagonal strain below minus one half")
    // reset blocks requests and drops any result in flight
    `GLS_ASSERT_NEXT(a_reset_flush, i_clk, !i_rst_n, (busy && !o_strobe), "reset did not flush")

endmodule

@@ bench/green_lagrange_strain_2d_test.sv @@
// self-checking testbench for the green-lagrange strain block
module green_lagrange_strain_2d_test;
    import gls_pkg::*;

    // clocking and run length
    localparam int CLK_HALF      = 2;
    localparam int RST_CYCLES    = 5;
    localparam int RANDOM_ITEMS  = 750;
    localparam int SEGMENT_ITEMS = 50;
    localparam int DRAIN_LIMIT   = 200;
    localparam int LATENCY_PAD   = 10;
    localparam int RUN_CYCLES    = 200000;
    localparam int MAX_REPORTS   = 10;

    // fixed point limits of one data word
    localparam longint WORD_MAX = (longint'(1) <<< (DATA_WIDTH_DEF - 1)) - 1;
    localparam longint WORD_MIN = -(longint'(1) <<< (DATA_WIDTH_DEF - 1));
    localparam longint ONE_FIX  = longint'(1) <<< FRAC_BITS_DEF;
    localparam longint HALF_FIX = longint'(1) <<< (FRAC_BITS_DEF - 1);

    // handy q16.16 words for the directed requests
    localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_gls_req i_req   = '0;
    logic     o_strobe;
    t_gls_res o_res;

    // results still owed by the block, oldest first
    t_gls_res pending_strain_q[$];
    t_gls_res head_res;

    int  fault_count    = 0;
    int  mismatch_count = 0;
    bit  idle_on        = 1'b1;

    green_lagrange_strain_2d u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // strain predictor
    // ------------------------------------------------------------------

    // clip to the signed word range and remember that a clip happened
    function automatic longint sat_word(input longint v, inout bit clipped);
        if (v > WORD_MAX) begin
            clipped = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            clipped = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // exact product, floor shift by the fraction bits, then clip
    function automatic longint mul_fix(input longint a, input longint b, inout bit clipped);
        return sat_word((a * b) >>> FRAC_BITS_DEF, clipped);
    endfunction

    // H = sum u(n,i)*g(n,j), F = I + H, E = floor(F^T F / 2) - I/2
    function automatic t_gls_res calc_strain(input t_gls_req req);
        longint   disp[3][2];
        longint   grad[3][2];
        longint   fg[2][2];
        longint   eg[2][2];
        longint   acc;
        bit       clipped;
        int       i;
        int       j;
        int       n;
        t_gls_res res;

        clipped    = 1'b0;
        disp[0][0] = req.disp_n0_x;
        disp[0][1] = req.disp_n0_y;
        disp[1][0] = req.disp_n1_x;
        disp[1][1] = req.disp_n1_y;
        disp[2][0] = req.disp_n2_x;
        disp[2][1] = req.disp_n2_y;
        grad[0][0] = req.grad_n0_x;
        grad[0][1] = req.grad_n0_y;
        grad[1][0] = req.grad_n1_x;
        grad[1][1] = req.grad_n1_y;
        grad[2][0] = req.grad_n2_x;
        grad[2][1] = req.grad_n2_y;

        for (i = 0; i < 2; i++) begin
            for (j = 0; j < 2; j++) begin
                acc = 0;
                for (n = 0; n < 3; n++) begin
                    acc += mul_fix(disp[n][i], grad[n][j], clipped);
                end
                acc = sat_word(acc, clipped);
                if (i == j) begin
                    acc = sat_word(acc + ONE_FIX, clipped);
                end
                fg[i][j] = acc;
            end
        end

        // right cauchy-green sum keeps one extra bit, only the halved value is clipped
        for (i = 0; i < 2; i++) begin
            for (j = 0; j < 2; j++) begin
                acc = mul_fix(fg[0][i], fg[0][j], clipped)
                    + mul_fix(fg[1][i], fg[1][j], clipped);
                acc = acc >>> 1;
                if (i == j) begin
                    acc -= HALF_FIX;
                end
                eg[i][j] = sat_word(acc, clipped);
            end
        end

        res.def_grad_xx = 32'(fg[0][0]);
        res.def_grad_xy = 32'(fg[0][1]);
        res.def_grad_yx = 32'(fg[1][0]);
        res.def_grad_yy = 32'(fg[1][1]);
        res.strain_xx   = 32'(eg[0][0]);
        res.strain_xy   = 32'(eg[0][1]);
        res.strain_yx   = 32'(eg[1][0]);
        res.strain_yy   = 32'(eg[1][1]);
        res.saturated   = clipped;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fault_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    // one process compares each strobed result, then records the request
    // taken at the same edge, so a fresh request never meets its own result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                if (pending_strain_q.size() == 0) begin
                    fault_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result strobed with no request pending: %h", o_res);
                    end
                end else begin
                    head_res = pending_strain_q.pop_front();
                    check_field("def_grad_xx", head_res.def_grad_xx, o_res.def_grad_xx);
                    check_field("def_grad_xy", head_res.def_grad_xy, o_res.def_grad_xy);
                    check_field("def_grad_yx", head_res.def_grad_yx, o_res.def_grad_yx);
                    check_field("def_grad_yy", head_res.def_grad_yy, o_res.def_grad_yy);
                    check_field("strain_xx", head_res.strain_xx, o_res.strain_xx);
                    check_field("strain_xy", head_res.strain_xy, o_res.strain_xy);
                    check_field("strain_yx", head_res.strain_yx, o_res.strain_yx);
                    check_field("strain_yy", head_res.strain_yy, o_res.strain_yy);
                    check_field("saturated", {31'b0, head_res.saturated},
                                {31'b0, o_res.saturated});
                end
            end else if (o_strobe !== 1'b0) begin
                fault_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("strobe is unknown");
                end
            end
            if (start && busy === 1'b0) begin
                pending_strain_q.push_back(calc_strain(i_req));
            end
        end
    end

    // ------------------------------------------------------------------
    // request driving
    // ------------------------------------------------------------------

    // mostly back to back, some short pauses, a few long ones
    function automatic int pick_gap();
        int roll;
        if (!idle_on) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // present one request and hold it until an edge with busy low takes it
    task automatic send_strain_req(input t_gls_req req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_fields(input logic [31:0] d0x, d0y, d1x, d1y, d2x, d2y,
                               input logic [31:0] g0x, g0y, g1x, g1y, g2x, g2y);
        send_strain_req({d0x, d0y, d1x, d1y, d2x, d2y, g0x, g0y, g1x, g1y, g2x, g2y});
    endtask

    // uniform value in [-span, span] raw units
    function automatic logic [31:0] near_zero(input int span);
        return 32'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // a word biased toward the corners of the range
    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 7))
            0: return Q_ZERO;
            1: return Q_ONE;
            2: return Q_NEG_ONE;
            3: return Q_MAX;
            4: return Q_MIN;
            5: return 32'hFFFF_FFFF;
            6: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // undeformed element and rigid translation both give F = I, E = 0
    task automatic test_rest_state();
        send_fields(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_fields(32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
                    32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
                    Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ONE);
    endtask

    // one gradient entry at a time on the unit right triangle, then all four together
    task automatic test_stretch_and_shear();
        send_fields(Q_ZERO, Q_ZERO, Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ONE);
        send_fields(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 32'h0000_4000, Q_ZERO,
                    Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ONE);
        send_fields(Q_ZERO, Q_ZERO, Q_ZERO, 32'hFFFF_4000, Q_ZERO, Q_ZERO,
                    Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ONE);
        // full compression along y leaves F_yy at zero
        send_fields(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE,
                    Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ONE);
        send_fields(Q_ZERO, Q_ZERO, 32'h0000_199A, 32'h0000_3333,
                    32'hFFFF_B334, 32'h0000_0CCD,
                    Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ONE);
    endtask

    // products round toward minus infinity, not toward zero
    task automatic test_truncation();
        send_fields(32'hFFFF_FFFF, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    32'h0000_0001, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_fields(32'h0000_0003, 32'hFFFF_FFFD, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_HALF, Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
    endtask

    // a product landing exactly on the minimum, just past the maximum, far past, then uniform and patterned words
    task automatic test_product_limits();
        send_fields(Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_fields(Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_ZERO, Q_NEG_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_fields(Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_fields(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                    Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_fields(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                    Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_fields('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        send_fields(32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1,
                    32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
        send_fields(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    // unclipped products whose sum overflows, and the identity add at the edge
    task automatic test_sum_and_identity_clip();
        send_fields(32'h4000_0000, Q_ZERO, 32'h4000_0000, Q_ZERO, 32'h4000_0000, Q_ZERO,
                    Q_ONE, Q_ZERO, Q_ONE, Q_ZERO, Q_ONE, Q_ZERO);
        send_fields(32'h4000_0000, Q_ZERO, 32'h4000_0000, Q_ZERO, 32'h4000_0000, Q_ZERO,
                    Q_NEG_ONE, Q_ZERO, Q_NEG_ONE, Q_ZERO, Q_NEG_ONE, Q_ZERO);
        send_fields(32'h7FFF_0000, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_fields(32'h7FFE_FFFF, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_fields(Q_ZERO, Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                    Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
    endtask

    // mostly physical elements (small displacements, gradients summing to
    // zero), some fully random words and some corner-heavy requests;
    // idling is switched per segment so back-to-back stretches occur
    task automatic test_random_points();
        int          k;
        int          roll;
        logic [31:0] g1x;
        logic [31:0] g1y;
        logic [31:0] g2x;
        logic [31:0] g2y;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % SEGMENT_ITEMS == 0) begin
                idle_on = (k == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                g1x = near_zero(262144);
                g1y = near_zero(262144);
                g2x = near_zero(262144);
                g2y = near_zero(262144);
                send_fields(near_zero(131072), near_zero(131072), near_zero(131072),
                            near_zero(131072), near_zero(131072), near_zero(131072),
                            -(g1x + g2x), -(g1y + g2y), g1x, g1y, g2x, g2y);
            end else if (roll < 90) begin
                send_fields($urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom(), $urandom());
            end else begin
                send_fields(corner_word(), corner_word(), corner_word(), corner_word(),
                            corner_word(), corner_word(), corner_word(), corner_word(),
                            corner_word(), corner_word(), corner_word(), corner_word());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        int drain_wait;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_rest_state();
        test_stretch_and_shear();
        test_truncation();
        test_product_limits();
        test_sum_and_identity_clip();
        test_random_points();

        // let the pipeline empty, then keep watching for stray strobes
        start      <= 1'b0;
        drain_wait  = 0;
        while (pending_strain_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (LATENCY_PAD) @(posedge i_clk);
        fault_count += pending_strain_q.size();

        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog for a block that stays busy or a stimulus that hangs
    initial begin
        #(RUN_CYCLES * 2 * CLK_HALF);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/gls_pkg.sv
rtl/core/gls_prod.sv
rtl/core/green_lagrange_strain_2d.sv
bench/green_lagrange_strain_2d_test.sv
